/* design/lsgd_pkg.sv */
// shared types, constants and the sigmoid table for the logistic sgd trainer
// no dependencies; used by the interfaces, controller, datapath and top level
package lsgd_pkg;

    localparam int NUM_WEIGHTS     = 16;
    localparam int SIGMOID_ENTRIES = 256;
    localparam int IDX_W  = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
    localparam int CNT_W  = $clog2(NUM_WEIGHTS + 1);
    localparam int SIG_W  = $clog2(SIGMOID_ENTRIES);
    localparam int ACC_W  = 48 + $clog2(NUM_WEIGHTS) + 1;

    localparam int FEAT_W   = 16;
    localparam int TGT_W    = 16;
    localparam int WGT_W    = 32;
    localparam int WIDX_W   = 6;
    localparam int LR_W     = 16;
    localparam int TOL_W    = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE     = 1'd1;
    localparam logic [LR_W-1:0]  LR_RESET  = 16'd6554;
    localparam logic [TOL_W-1:0] TOL_RESET = 24'd168;

    typedef logic [15:0] sig_table_t [SIGMOID_ENTRIES];

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TR_CHECK,
        ST_MAC,
        ST_MAC_END,
        ST_SIG,
        ST_ERR,
        ST_UPD,
        ST_WR,
        ST_EP_MUL,
        ST_EP_CMP,
        ST_REPORT
    } lsgd_state_t;

    typedef struct packed {
        logic             feat_we;
        logic [IDX_W-1:0] feat_addr;
        logic             tgt_cap;
        logic [IDX_W-1:0] rd_addr;
        logic             acc_clr;
        logic             mul_en;
        logic             sig_en;
        logic             err_en;
        logic             upd_en;
        logic             wgt_we;
        logic             ep_mul_en;
        logic             ep_cmp_en;
        logic             out_load;
        logic             out_last;
    } lsgd_cmd_t;

    typedef struct packed {
        logic frozen_sel;
        logic out_busy;
    } lsgd_status_t;

    function automatic sig_table_t build_sig_table();
        sig_table_t  t;
        logic [63:0] c;
        logic [63:0] a;
        logic [63:0] y;
        logic [63:0] y2;
        logic [63:0] y3;
        logic [63:0] y4;
        logic [63:0] v;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] s;
        logic        neg;
        for (int k = 0; k < SIGMOID_ENTRIES; k++)
        begin
            c   = (64'(2 * k + 1) << 35) / SIGMOID_ENTRIES;
            neg = c < (64'd8 << 32);
            a   = neg ? (64'd8 << 32) - c : c - (64'd8 << 32);
            y   = a >> 8;
            y2  = (y * y) >> 32;
            y3  = (y2 * y) >> 32;
            y4  = (y3 * y) >> 32;
            v   = (64'd1 << 32) - y + y2 / 2 - y3 / 6 + y4 / 24;
            for (int n = 0; n < 8; n++)
            begin
                if (v > 64'hFFFF_FFFF)
                    v = 64'hFFFF_FFFF;
                v = (v * v) >> 32;
            end
            den = (64'd1 << 32) + v;
            num = (64'd1 << 47) + (den >> 1);
            rem = '0;
            s   = '0;
            for (int b = 63; b >= 0; b--)
            begin
                rem = {rem[62:0], num[b]};
                if (rem >= den)
                begin
                    rem  = rem - den;
                    s[b] = 1'b1;
                end
            end
            t[k] = neg ? 16'(64'd32768 - s) : s[15:0];
        end
        return t;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

/* design/lsgd_in_if.sv */
// input channel: one feature per item with label and epoch marker
// depends on lsgd_pkg
interface lsgd_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [lsgd_pkg::FEAT_W-1:0] feature_value;
    logic [lsgd_pkg::TGT_W-1:0]      target_value;
    logic                            end_of_epoch;

    modport source (output valid, feature_value, target_value, end_of_epoch, input ready);
    modport sink (input valid, feature_value, target_value, end_of_epoch, output ready);
endinterface

/* design/lsgd_out_if.sv */
// output channel: one weight report per item
// depends on lsgd_pkg
interface lsgd_out_if;
    logic                               valid;
    logic                               ready;
    logic [lsgd_pkg::WIDX_W-1:0]        weight_index;
    logic signed [lsgd_pkg::WGT_W-1:0]  weight_value;
    logic                               frozen;
    logic                               converged;
    logic                               last_weight;

    modport source (output valid, weight_index, weight_value, frozen, converged, last_weight,
                    input ready);
    modport sink (input valid, weight_index, weight_value, frozen, converged, last_weight,
                  output ready);
endinterface

/* design/logistic_sgd_trainer_top.sv */
// Logistic regression trainer. Features stream in one per item and are
// accepted while the block is idle; an item that completes an example or
// marks an epoch end makes the block busy. After an example's last
// feature the block updates every non-frozen weight in turn, each with a
// 16-term dot product on one shared multiply-accumulate unit, then a
// sigmoid lookup, error, update and weight write. An epoch-end item adds a
// freeze test of every weight and then reports all 16 weights, one per
// cycle while the sink takes them. Configuration writes only while idle:
// a rule for the user, which the block itself does not enforce.
// depends on lsgd_pkg, lsgd_in_if, lsgd_out_if, lsgd_ctrl, lsgd_dp
module logistic_sgd_trainer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lsgd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsgd_pkg::CFG_DAT_W-1:0]  cfg_data,
    lsgd_in_if.sink                         in_ch,
    lsgd_out_if.source                      out_ch
);

    lsgd_pkg::lsgd_cmd_t    cmd;
    lsgd_pkg::lsgd_status_t status;

    lsgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_eoe   (in_ch.end_of_epoch),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .status   (status)
    );

    lsgd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_feature    (in_ch.feature_value),
        .in_target     (in_ch.target_value),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .out_index     (out_ch.weight_index),
        .out_weight    (out_ch.weight_value),
        .out_frozen    (out_ch.frozen),
        .out_converged (out_ch.converged),
        .out_last      (out_ch.last_weight)
    );

endmodule

/* design/lsgd_ctrl.sv */
// controller state machine: sequences feature capture, training, freeze test and report
// depends on lsgd_pkg
module lsgd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_eoe,
    output logic                   in_ready,
    output lsgd_pkg::lsgd_cmd_t    cmd,
    input  lsgd_pkg::lsgd_status_t status
);

    lsgd_pkg::lsgd_state_t         state_reg, state_next;
    logic [lsgd_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [lsgd_pkg::CNT_W-1:0]    idx_reg, idx_next;
    logic [lsgd_pkg::CNT_W-1:0]    j_reg, j_next;
    logic                          eoe_reg, eoe_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsgd_pkg::ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            j_reg     <= '0;
            eoe_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            j_reg     <= j_next;
            eoe_reg   <= eoe_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        j_next     = j_reg;
        eoe_next   = eoe_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.feat_addr = cnt_reg[lsgd_pkg::IDX_W-1:0];
        cmd.rd_addr   = idx_reg[lsgd_pkg::IDX_W-1:0];
        unique case (state_reg)
            lsgd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.feat_we = 1'b1;
                    if (cnt_reg == lsgd_pkg::CNT_W'(lsgd_pkg::NUM_WEIGHTS - 1))
                    begin
                        cmd.tgt_cap = 1'b1;
                        cnt_next    = '0;
                        idx_next    = '0;
                        eoe_next    = in_eoe;
                        state_next  = lsgd_pkg::ST_TR_CHECK;
                    end
                    else if (in_eoe)
                    begin
                        cnt_next   = '0;
                        idx_next   = '0;
                        state_next = lsgd_pkg::ST_EP_MUL;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            lsgd_pkg::ST_TR_CHECK:
            begin
                if (idx_reg == lsgd_pkg::CNT_W'(lsgd_pkg::NUM_WEIGHTS))
                begin
                    idx_next   = '0;
                    state_next = eoe_reg ? lsgd_pkg::ST_EP_MUL : lsgd_pkg::ST_IDLE;
                end
                else if (status.frozen_sel)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    cmd.acc_clr = 1'b1;
                    j_next      = '0;
                    state_next  = lsgd_pkg::ST_MAC;
                end
            end
            lsgd_pkg::ST_MAC:
            begin
                cmd.rd_addr = j_reg[lsgd_pkg::IDX_W-1:0];
                cmd.mul_en  = 1'b1;
                if (j_reg == lsgd_pkg::CNT_W'(lsgd_pkg::NUM_WEIGHTS - 1))
                    state_next = lsgd_pkg::ST_MAC_END;
                else
                    j_next = j_reg + 1'b1;
            end
            lsgd_pkg::ST_MAC_END:
            begin
                state_next = lsgd_pkg::ST_SIG;
            end
            lsgd_pkg::ST_SIG:
            begin
                cmd.sig_en = 1'b1;
                state_next = lsgd_pkg::ST_ERR;
            end
            lsgd_pkg::ST_ERR:
            begin
                cmd.err_en = 1'b1;
                state_next = lsgd_pkg::ST_UPD;
            end
            lsgd_pkg::ST_UPD:
            begin
                cmd.upd_en = 1'b1;
                state_next = lsgd_pkg::ST_WR;
            end
            lsgd_pkg::ST_WR:
            begin
                cmd.wgt_we = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = lsgd_pkg::ST_TR_CHECK;
            end
            lsgd_pkg::ST_EP_MUL:
            begin
                cmd.ep_mul_en = 1'b1;
                state_next    = lsgd_pkg::ST_EP_CMP;
            end
            lsgd_pkg::ST_EP_CMP:
            begin
                cmd.ep_cmp_en = 1'b1;
                if (idx_reg == lsgd_pkg::CNT_W'(lsgd_pkg::NUM_WEIGHTS - 1))
                begin
                    idx_next   = '0;
                    state_next = lsgd_pkg::ST_REPORT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = lsgd_pkg::ST_EP_MUL;
                end
            end
            lsgd_pkg::ST_REPORT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    if (idx_reg == lsgd_pkg::CNT_W'(lsgd_pkg::NUM_WEIGHTS - 1))
                    begin
                        cmd.out_last = 1'b1;
                        idx_next     = '0;
                        state_next   = lsgd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = lsgd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* design/lsgd_dp.sv */
// datapath: feature and weight stores, shared mac, sigmoid lookup, update and freeze test
// depends on lsgd_pkg
module lsgd_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lsgd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsgd_pkg::CFG_DAT_W-1:0]      cfg_data,
    input  logic signed [lsgd_pkg::FEAT_W-1:0]  in_feature,
    input  logic [lsgd_pkg::TGT_W-1:0]          in_target,
    input  lsgd_pkg::lsgd_cmd_t                 cmd,
    output lsgd_pkg::lsgd_status_t              status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [lsgd_pkg::WIDX_W-1:0]         out_index,
    output logic signed [lsgd_pkg::WGT_W-1:0]   out_weight,
    output logic                                out_frozen,
    output logic                                out_converged,
    output logic                                out_last
);

    logic [lsgd_pkg::LR_W-1:0]             lr_reg;
    logic [lsgd_pkg::TOL_W-1:0]            tol_reg;
    logic signed [lsgd_pkg::FEAT_W-1:0]    feat_reg [lsgd_pkg::NUM_WEIGHTS];
    logic signed [lsgd_pkg::WGT_W-1:0]     wgt_reg  [lsgd_pkg::NUM_WEIGHTS];
    logic signed [lsgd_pkg::WGT_W-1:0]     prev_reg [lsgd_pkg::NUM_WEIGHTS];
    logic [lsgd_pkg::NUM_WEIGHTS-1:0]      frozen_reg;
    logic [lsgd_pkg::TGT_W-1:0]            tgt_reg;
    logic signed [47:0]                    prod_reg;
    logic                                  prod_vld_reg;
    logic signed [lsgd_pkg::ACC_W-1:0]     acc_reg;
    logic [15:0]                           h_reg;
    logic signed [33:0]                    m1_reg;
    logic signed [49:0]                    m2_reg;
    logic [55:0]                           tm_reg;
    logic [32:0]                           diff_reg;
    logic                                  zero_reg;
    logic                                  ov_reg;
    logic [lsgd_pkg::WIDX_W-1:0]           oidx_reg;
    logic signed [lsgd_pkg::WGT_W-1:0]     ow_reg;
    logic                                  ofz_reg;
    logic                                  ocv_reg;
    logic                                  olast_reg;

    logic signed [lsgd_pkg::FEAT_W-1:0]    f_rd;
    logic signed [lsgd_pkg::WGT_W-1:0]     w_rd;
    logic signed [lsgd_pkg::WGT_W-1:0]     p_rd;
    logic signed [lsgd_pkg::ACC_W-1:0]     shifted;
    logic [lsgd_pkg::SIG_W-1:0]            sig_idx;
    logic signed [17:0]                    err;
    logic signed [50:0]                    rounded;
    logic signed [32:0]                    wsum;
    logic signed [lsgd_pkg::WGT_W-1:0]     wsat;
    logic signed [32:0]                    d;
    logic [32:0]                           diff;
    logic [32:0]                           negp;
    logic [31:0]                           mag;
    logic                                  below_tol;

    assign f_rd = feat_reg[cmd.rd_addr];
    assign w_rd = wgt_reg[cmd.rd_addr];
    assign p_rd = prev_reg[cmd.rd_addr];

    always_comb
    begin
        shifted = acc_reg + lsgd_pkg::ACC_W'(64'd1 << 31);
        if (shifted[lsgd_pkg::ACC_W-1])
            sig_idx = '0;
        else if (|shifted[lsgd_pkg::ACC_W-2:32])
            sig_idx = '1;
        else
            sig_idx = shifted[31 -: lsgd_pkg::SIG_W];
    end

    assign err     = $signed({2'b00, tgt_reg}) - $signed({2'b00, h_reg});
    assign rounded = 51'(m2_reg) + 51'(64'd1 << 26);
    assign wsum    = 33'(w_rd) + 33'($signed(rounded[50:27]));

    always_comb
    begin
        if (wsum[32] != wsum[31])
            wsat = wsum[32] ? {1'b1, {(lsgd_pkg::WGT_W-1){1'b0}}}
                            : {1'b0, {(lsgd_pkg::WGT_W-1){1'b1}}};
        else
            wsat = wsum[31:0];
    end

    assign d    = 33'(w_rd) - 33'(p_rd);
    assign diff = d[32] ? 33'(-d) : 33'(d);
    assign negp = 33'(-33'(p_rd));
    assign mag  = p_rd[31] ? negp[31:0] : p_rd[31:0];

    always_comb
    begin
        if (zero_reg)
            below_tol = {diff_reg, 8'b0} < 41'(tol_reg);
        else
            below_tol = {diff_reg, 24'b0} < 57'(tm_reg);
    end

    assign status.frozen_sel = frozen_reg[cmd.rd_addr];
    assign status.out_busy   = ov_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg  <= lsgd_pkg::LR_RESET;
            tol_reg <= lsgd_pkg::TOL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsgd_pkg::CFG_LEARNING_RATE: lr_reg  <= cfg_data[lsgd_pkg::LR_W-1:0];
                lsgd_pkg::CFG_TOLERANCE:     tol_reg <= cfg_data[lsgd_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < lsgd_pkg::NUM_WEIGHTS; n++)
            begin
                wgt_reg[n]  <= '0;
                prev_reg[n] <= '0;
            end
            frozen_reg   <= '0;
            prod_vld_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= cmd.mul_en;
            if (cmd.wgt_we)
                wgt_reg[cmd.rd_addr] <= wsat;
            if (cmd.ep_cmp_en)
            begin
                prev_reg[cmd.rd_addr] <= w_rd;
                if (below_tol)
                    frozen_reg[cmd.rd_addr] <= 1'b1;
            end
            if (cmd.out_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.feat_we)
            feat_reg[cmd.feat_addr] <= in_feature;
        if (cmd.tgt_cap)
            tgt_reg <= in_target;
        if (cmd.mul_en)
            prod_reg <= 48'(f_rd) * 48'(w_rd);
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (prod_vld_reg)
            acc_reg <= acc_reg + lsgd_pkg::ACC_W'(prod_reg);
        if (cmd.sig_en)
            h_reg <= lsgd_pkg::SIG_TABLE[sig_idx];
        if (cmd.err_en)
            m1_reg <= 34'($signed({1'b0, lr_reg})) * 34'(err);
        if (cmd.upd_en)
            m2_reg <= 50'(m1_reg) * 50'(f_rd);
        if (cmd.ep_mul_en)
        begin
            tm_reg   <= 56'(tol_reg) * 56'(mag);
            diff_reg <= diff;
            zero_reg <= (p_rd == '0);
        end
        if (cmd.out_load)
        begin
            oidx_reg  <= lsgd_pkg::WIDX_W'(cmd.rd_addr);
            ow_reg    <= w_rd;
            ofz_reg   <= frozen_reg[cmd.rd_addr];
            ocv_reg   <= &frozen_reg;
            olast_reg <= cmd.out_last;
        end
    end

    assign out_valid     = ov_reg;
    assign out_index     = oidx_reg;
    assign out_weight    = ow_reg;
    assign out_frozen    = ofz_reg;
    assign out_converged = ocv_reg;
    assign out_last      = olast_reg;

endmodule
